// ===== rtl/artdmx_packet_receiver_top_defines.svh =====
// ---------------------------------------------------------------------------
// artdmx packet receiver assertion macros
// concurrent assertion helpers shared by the checker
// ---------------------------------------------------------------------------
`ifndef ARTDMX_PACKET_RECEIVER_TOP_DEFINES_SVH
`define ARTDMX_PACKET_RECEIVER_TOP_DEFINES_SVH

// clocked assertion, off while reset is high
`define ARTDMX_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ARTDMX_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/artdmx_pkg.sv =====
// ---------------------------------------------------------------------------
// artdmx package
// types, constants and register indexes of the artdmx packet receiver
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package artdmx_pkg;

   localparam int FRAME_BYTES_DEFAULT    = 12288;
   localparam int UNIVERSE_BYTES_DEFAULT = 512;
   localparam int NUM_NETS_DEFAULT       = 2;

   localparam int ADDR_WIDTH      = 14;
   localparam int POS_WIDTH       = 10;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   // power of two, pointers wrap
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DISPLAY_NET = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MIN_VERSION = 1'b1;

   localparam logic [15:0] OPCODE_DMX          = 16'h5000;
   localparam logic [15:0] MIN_VERSION_DEFAULT = 16'd14;
   localparam logic        DISPLAY_NET_DEFAULT = 1'b1;
   localparam logic [8:0]  SEQ_NONE            = 9'h1FF;

   localparam int ID_LENGTH = 8;
   localparam logic [7:0] ID_BYTES [ID_LENGTH] = '{
      8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00
   };

   localparam logic [POS_WIDTH-1:0] POS_ID_END     = 10'd8;
   localparam logic [POS_WIDTH-1:0] POS_OPCODE_LO  = 10'd8;
   localparam logic [POS_WIDTH-1:0] POS_OPCODE_HI  = 10'd9;
   localparam logic [POS_WIDTH-1:0] POS_VERSION_HI = 10'd10;
   localparam logic [POS_WIDTH-1:0] POS_VERSION_LO = 10'd11;
   localparam logic [POS_WIDTH-1:0] POS_SEQUENCE   = 10'd12;
   localparam logic [POS_WIDTH-1:0] POS_UNIVERSE   = 10'd14;
   localparam logic [POS_WIDTH-1:0] POS_NET        = 10'd15;
   localparam logic [POS_WIDTH-1:0] POS_LENGTH_HI  = 10'd16;
   localparam logic [POS_WIDTH-1:0] POS_LENGTH_LO  = 10'd17;
   localparam logic [POS_WIDTH-1:0] POS_DATA_START = 10'd18;
   localparam logic [POS_WIDTH-1:0] POS_MAX        = 10'd1023;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } artdmx_req_type;

   typedef struct packed {
      logic                  write_enable;
      logic [ADDR_WIDTH-1:0] write_address;
      logic [7:0]            write_data;
      logic                  show_frame;
   } artdmx_rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } artdmx_queue_status_type;

endpackage

// ===== rtl/artdmx_packet_receiver_top.sv =====
// ---------------------------------------------------------------------------
// artdmx packet receiver top
// ArtDmx packet parser producing frame-buffer writes and show_frame marks
// ---------------------------------------------------------------------------
// usage
//   req_ channel: one UDP payload byte per transfer, last_byte on the final one
//   rsp_ channel: one result per data byte that lands in the frame buffer, and
//     on the final byte when the display net's sequence changed; bytes that
//     cause nothing produce no transfer
//   csr_ channel: index 0 display_net, index 1 min_protocol_version; csr_ready
//     is always high, write only while no packet is in flight
//   throughput: one byte per cycle, header and data alike, while req_stall is low
//   path: a result is pushed into the queue as its byte is taken, then moved
//     from the queue into the output register that drives rsp_valid
//   stall: a two-entry queue plus the output register absorb results while
//     rsp_stall is high; req_stall rises once the queue is full
//   reset: parser back at the packet start, no sequence seen on either net,
//     registers at their defaults, queue and output register empty
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module artdmx_packet_receiver_top #(
   parameter int FRAME_BYTES    = artdmx_pkg::FRAME_BYTES_DEFAULT,
   parameter int UNIVERSE_BYTES = artdmx_pkg::UNIVERSE_BYTES_DEFAULT,
   parameter int NUM_NETS       = artdmx_pkg::NUM_NETS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  artdmx_pkg::artdmx_req_type             req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output artdmx_pkg::artdmx_rsp_type             rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [artdmx_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [artdmx_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import artdmx_pkg::*;

   logic                    item_take;
   logic                    push;
   logic                    pop;
   artdmx_rsp_type          push_data;
   artdmx_rsp_type          pop_data;
   artdmx_queue_status_type status;

   assign csr_ready = 1'b1;
   assign req_stall = status.full;
   assign item_take = req_valid && !status.full;

   artdmx_parser #(
      .FRAME_BYTES   (FRAME_BYTES),
      .UNIVERSE_BYTES(UNIVERSE_BYTES),
      .NUM_NETS      (NUM_NETS)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .csr_write(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .item_take(item_take),
      .item_data(req_data),
      .push     (push),
      .push_data(push_data)
   );

   artdmx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .pop_data (pop_data),
      .status   (status)
   );

   artdmx_output u_output (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/artdmx_parser.sv =====
// ---------------------------------------------------------------------------
// artdmx parser
// front end: header capture, packet checks, frame-buffer write and show_frame decode
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module artdmx_parser #(
   parameter int FRAME_BYTES    = artdmx_pkg::FRAME_BYTES_DEFAULT,
   parameter int UNIVERSE_BYTES = artdmx_pkg::UNIVERSE_BYTES_DEFAULT,
   parameter int NUM_NETS       = artdmx_pkg::NUM_NETS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [artdmx_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [artdmx_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                                   item_take,
   input  artdmx_pkg::artdmx_req_type             item_data,
   output logic                                   push,
   output artdmx_pkg::artdmx_rsp_type             push_data
);
   import artdmx_pkg::*;

   localparam int CALC_WIDTH = ADDR_WIDTH + 1;

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic                 header_valid_ff, header_valid_in;
   logic [15:0]          opcode_ff, opcode_in;
   logic [15:0]          version_ff, version_in;
   logic [7:0]           sequence_ff, sequence_in;
   logic [3:0]           universe_ff, universe_in;
   logic [7:0]           net_ff, net_in;
   logic [7:0]           length_hi_ff, length_hi_in;
   logic [POS_WIDTH-1:0] length_ff, length_in;
   logic [8:0]           prev_seq_ff [2];
   logic [8:0]           prev_seq_in [2];
   logic                 display_net_ff, display_net_in;
   logic [15:0]          min_version_ff, min_version_in;

   logic                  accepted;
   logic [POS_WIDTH-1:0]  offset;
   logic [4:0]            block_index;
   logic [CALC_WIDTH-1:0] calc_addr;
   logic [15:0]           raw_length;
   logic                  write_hit;
   logic                  show_hit;

   always_comb begin
      accepted = header_valid_ff && (opcode_ff == OPCODE_DMX) &&
                 (version_ff >= min_version_ff) && (net_ff < 8'(NUM_NETS));
      offset      = pos_ff - POS_DATA_START;
      block_index = {net_ff[0], universe_ff};
      calc_addr   = CALC_WIDTH'(UNIVERSE_BYTES) * CALC_WIDTH'(block_index) +
                    CALC_WIDTH'(offset);
      raw_length  = {length_hi_ff, item_data.in_byte};
      write_hit   = (pos_ff >= POS_DATA_START) && (pos_ff < POS_MAX) &&
                    (offset < length_ff) && accepted &&
                    (calc_addr < CALC_WIDTH'(FRAME_BYTES));
      show_hit    = item_data.last_byte && (pos_ff >= POS_LENGTH_LO) && accepted &&
                    (net_ff[0] == display_net_ff) &&
                    (prev_seq_ff[net_ff[0]] != {1'b0, sequence_ff});
   end

   always_comb begin
      pos_in          = pos_ff;
      header_valid_in = header_valid_ff;
      opcode_in       = opcode_ff;
      version_in      = version_ff;
      sequence_in     = sequence_ff;
      universe_in     = universe_ff;
      net_in          = net_ff;
      length_hi_in    = length_hi_ff;
      length_in       = length_ff;
      prev_seq_in     = prev_seq_ff;
      if (item_take) begin
         if (pos_ff < POS_ID_END) begin
            if (item_data.in_byte != ID_BYTES[pos_ff[2:0]]) begin
               header_valid_in = 1'b0;
            end
         end else begin
            case (pos_ff)
               POS_OPCODE_LO:  opcode_in[7:0]   = item_data.in_byte;
               POS_OPCODE_HI:  opcode_in[15:8]  = item_data.in_byte;
               POS_VERSION_HI: version_in[15:8] = item_data.in_byte;
               POS_VERSION_LO: version_in[7:0]  = item_data.in_byte;
               POS_SEQUENCE:   sequence_in      = item_data.in_byte;
               POS_UNIVERSE:   universe_in      = item_data.in_byte[3:0];
               POS_NET:        net_in           = item_data.in_byte;
               POS_LENGTH_HI:  length_hi_in     = item_data.in_byte;
               POS_LENGTH_LO: begin
                  if (raw_length > 16'(UNIVERSE_BYTES)) begin
                     length_in = POS_WIDTH'(UNIVERSE_BYTES);
                  end else begin
                     length_in = raw_length[POS_WIDTH-1:0];
                  end
               end
               default: ;
            endcase
         end
         if (item_data.last_byte) begin
            if ((pos_ff >= POS_LENGTH_LO) && accepted) begin
               prev_seq_in[net_ff[0]] = {1'b0, sequence_ff};
            end
            pos_in          = '0;
            header_valid_in = 1'b1;
         end else if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      display_net_in = display_net_ff;
      min_version_in = min_version_ff;
      if (csr_write) begin
         case (csr_index)
            REG_DISPLAY_NET: display_net_in = csr_data[0];
            REG_MIN_VERSION: min_version_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      push                    = item_take && (write_hit || show_hit);
      push_data.write_enable  = write_hit;
      push_data.write_address = write_hit ? calc_addr[ADDR_WIDTH-1:0] : '0;
      push_data.write_data    = write_hit ? item_data.in_byte : '0;
      push_data.show_frame    = show_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         header_valid_ff <= 1'b1;
         opcode_ff       <= '0;
         version_ff      <= '0;
         sequence_ff     <= '0;
         universe_ff     <= '0;
         net_ff          <= '0;
         length_hi_ff    <= '0;
         length_ff       <= '0;
         prev_seq_ff[0]  <= SEQ_NONE;
         prev_seq_ff[1]  <= SEQ_NONE;
         display_net_ff  <= DISPLAY_NET_DEFAULT;
         min_version_ff  <= MIN_VERSION_DEFAULT;
      end else begin
         pos_ff          <= pos_in;
         header_valid_ff <= header_valid_in;
         opcode_ff       <= opcode_in;
         version_ff      <= version_in;
         sequence_ff     <= sequence_in;
         universe_ff     <= universe_in;
         net_ff          <= net_in;
         length_hi_ff    <= length_hi_in;
         length_ff       <= length_in;
         prev_seq_ff     <= prev_seq_in;
         display_net_ff  <= display_net_in;
         min_version_ff  <= min_version_in;
      end
   end

endmodule

// ===== rtl/artdmx_queue.sv =====
// ---------------------------------------------------------------------------
// artdmx queue
// short result queue between the parser and the output stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module artdmx_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  artdmx_pkg::artdmx_rsp_type          push_data,
   input  logic                                pop,
   output artdmx_pkg::artdmx_rsp_type          pop_data,
   output artdmx_pkg::artdmx_queue_status_type status
);
   import artdmx_pkg::*;

   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   artdmx_rsp_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      pop_data     = entry_ff[rd_ptr_ff];
      status.full  = (count_ff == COUNT_WIDTH'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/artdmx_output.sv =====
// ---------------------------------------------------------------------------
// artdmx output stage
// back end: moves queued results into the response register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module artdmx_output (
   input  logic                                clock,
   input  logic                                reset,
   input  artdmx_pkg::artdmx_queue_status_type status,
   input  artdmx_pkg::artdmx_rsp_type          pop_data,
   output logic                                pop,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output artdmx_pkg::artdmx_rsp_type          rsp_data
);
   import artdmx_pkg::*;

   logic           valid_ff, valid_in;
   artdmx_rsp_type data_ff, data_in;

   always_comb begin
      pop      = !status.empty && (!valid_ff || !rsp_stall);
      valid_in = valid_ff;
      data_in  = data_ff;
      if (pop) begin
         valid_in = 1'b1;
         data_in  = pop_data;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/artdmx_checker.sv =====
// ---------------------------------------------------------------------------
// artdmx checker
// port-level assertions for the artdmx packet receiver, bound to the top
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "artdmx_packet_receiver_top_defines.svh"

module artdmx_checker #(
   parameter int FRAME_BYTES = artdmx_pkg::FRAME_BYTES_DEFAULT
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input artdmx_pkg::artdmx_rsp_type rsp_data
);

   `ARTDMX_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "rsp changed under stall")
   `ARTDMX_ASSERT(a_rsp_useful, rsp_valid |-> rsp_data.write_enable || rsp_data.show_frame, "empty result transfer")
   `ARTDMX_ASSERT(a_addr_range, rsp_valid && rsp_data.write_enable |-> int'(rsp_data.write_address) < FRAME_BYTES, "write past frame buffer")
   `ARTDMX_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid && !req_stall, "not empty after reset")

endmodule

bind artdmx_packet_receiver_top artdmx_checker #(.FRAME_BYTES(FRAME_BYTES)) u_checker (.*);
